>>> rtl/tpwg_pkg.sv
// Shared types and constants for the proximity and wave gesture detector.
package tpwg_pkg;

  // Distance code that means nothing is in range.
  localparam logic [7:0] NO_TARGET_MM = 8'd255;

  // Wave phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_IN   = 2'd1;
  localparam logic [1:0] PH_OUT  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE        = 3'd0;
  localparam logic [2:0] REG_POLL_INTERVAL = 3'd1;
  localparam logic [2:0] REG_PROX_THRESH   = 3'd2;
  localparam logic [2:0] REG_PROX_DEBOUNCE = 3'd3;
  localparam logic [2:0] REG_COOLDOWN      = 3'd4;
  localparam logic [2:0] REG_WAVE_NEAR     = 3'd5;
  localparam logic [2:0] REG_WAVE_WINDOW   = 3'd6;
  localparam logic [2:0] REG_WAVE_MIN      = 3'd7;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  distance_mm;
    logic        ack_proximity;
    logic        ack_wave;
  } in_item_t;

  typedef struct packed {
    logic       reading_taken;
    logic       proximity_event;
    logic       wave_event;
    logic [7:0] last_distance;
    logic [1:0] wave_phase;
    logic [7:0] crossing_count;
  } out_item_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] poll_interval_ms;
    logic [7:0]  prox_threshold_mm;
    logic [15:0] prox_debounce_ms;
    logic [15:0] cooldown_ms;
    logic [7:0]  wave_near_mm;
    logic [15:0] wave_window_ms;
    logic [7:0]  wave_min_crossings;
  } cfg_t;

  // An input beat after the distance has been classified.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  distance_mm;
    logic        ack_proximity;
    logic        ack_wave;
    logic        prox_hit;
    logic        near;
    logic        far;
  } cls_item_t;

endpackage

>>> rtl/tpwg_front.sv
// Front part: accepts input beats and classifies the distance against the thresholds.
module tpwg_front
  import tpwg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      cls_valid,
  input  logic      cls_ready,
  output cls_item_t cls_data
);

  logic front_valid;

  // The stage takes a new beat when empty or when its beat moves on.
  assign in_ready  = !front_valid || cls_ready;
  assign cls_valid = front_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (in_ready) begin
      front_valid <= in_valid;
    end
  end

  // Classification depends on configuration, which the user must keep static while items flow; not enforced here.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cls_data.now_ms        <= in_data.now_ms;
      cls_data.distance_mm   <= in_data.distance_mm;
      cls_data.ack_proximity <= in_data.ack_proximity;
      cls_data.ack_wave      <= in_data.ack_wave;
      cls_data.prox_hit      <= in_data.distance_mm <= cfg.prox_threshold_mm;
      cls_data.near          <= in_data.distance_mm <= cfg.wave_near_mm;
      cls_data.far           <= in_data.distance_mm == NO_TARGET_MM;
    end
  end

endmodule

>>> rtl/tpwg_queue.sv
// Short queue of classified beats between the front and back parts.
module tpwg_queue
  import tpwg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  cls_item_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output cls_item_t pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cls_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/tpwg_back.sv
// Back part: poll gating, proximity debounce, wave state machine and the output register.
module tpwg_back
  import tpwg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cls_valid,
  output logic      cls_ready,
  input  cls_item_t cls_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [31:0] last_poll_time;
  logic [7:0]  latest_distance;
  logic        prox_pending;
  logic [31:0] prox_start_time;
  logic        prox_flag;
  logic [1:0]  wave_state;
  logic [7:0]  wave_crossings;
  logic [31:0] window_start_time;
  logic        wave_flag;
  logic [31:0] cooldown_until;

  logic [31:0] last_poll_time_next;
  logic [7:0]  latest_distance_next;
  logic        prox_pending_next;
  logic [31:0] prox_start_time_next;
  logic        prox_flag_next;
  logic [1:0]  wave_state_next;
  logic [7:0]  wave_crossings_next;
  logic [31:0] window_start_time_next;
  logic        wave_flag_next;
  logic [31:0] cooldown_until_next;

  logic        step;
  logic        taken;
  logic [31:0] now;
  logic [31:0] poll_elapsed;
  logic [31:0] prox_elapsed;
  logic [31:0] window_elapsed;
  logic [31:0] cooldown_end;
  logic        expired;
  logic [7:0]  cross_inc;

  // A beat is stepped whenever the output register is free to take its result.
  assign cls_ready = !out_valid || out_ready;
  assign step      = cls_valid && cls_ready;

  assign now            = cls_data.now_ms;
  assign poll_elapsed   = now - last_poll_time;
  assign prox_elapsed   = now - prox_start_time;
  assign window_elapsed = now - window_start_time;
  assign cooldown_end   = now + {16'd0, cfg.cooldown_ms};
  assign expired        = window_elapsed > {16'd0, cfg.wave_window_ms};
  assign cross_inc      = wave_crossings + 8'd1;

  assign taken = cfg.enable && (now >= cooldown_until)
                 && (poll_elapsed >= {16'd0, cfg.poll_interval_ms});

  // Next state for one beat.
  always_comb begin
    last_poll_time_next    = last_poll_time;
    latest_distance_next   = latest_distance;
    prox_pending_next      = prox_pending;
    prox_start_time_next   = prox_start_time;
    prox_flag_next         = prox_flag && !cls_data.ack_proximity;
    wave_state_next        = wave_state;
    wave_crossings_next    = wave_crossings;
    window_start_time_next = window_start_time;
    wave_flag_next         = wave_flag && !cls_data.ack_wave;
    cooldown_until_next    = cooldown_until;

    if (taken) begin
      last_poll_time_next  = now;
      latest_distance_next = cls_data.distance_mm;

      // Proximity debounce; a set flag blocks a repeat event.
      if (cls_data.prox_hit) begin
        if (!prox_pending) begin
          prox_pending_next    = 1'b1;
          prox_start_time_next = now;
        end else if (!prox_flag_next && prox_elapsed >= {16'd0, cfg.prox_debounce_ms}) begin
          prox_flag_next      = 1'b1;
          cooldown_until_next = cooldown_end;
        end
      end else begin
        prox_pending_next    = 1'b0;
        prox_start_time_next = '0;
      end

      // Wave gesture state machine.
      case (wave_state)
        PH_IDLE: begin
          if (cls_data.near) begin
            wave_state_next        = PH_IN;
            wave_crossings_next    = 8'd1;
            window_start_time_next = now;
          end
        end
        PH_IN: begin
          if (expired) begin
            wave_state_next     = PH_IDLE;
            wave_crossings_next = '0;
          end else if (cls_data.far) begin
            wave_crossings_next = cross_inc;
            wave_state_next     = PH_OUT;
          end
        end
        default: begin
          if (expired) begin
            wave_state_next     = PH_IDLE;
            wave_crossings_next = '0;
          end else if (cls_data.near) begin
            if (cross_inc >= cfg.wave_min_crossings) begin
              wave_flag_next      = 1'b1;
              wave_state_next     = PH_IDLE;
              wave_crossings_next = '0;
              cooldown_until_next = cooldown_end;
            end else begin
              wave_crossings_next = cross_inc;
              wave_state_next     = PH_IN;
            end
          end
        end
      endcase
    end
  end

  // Detector state.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_poll_time    <= '0;
      latest_distance   <= NO_TARGET_MM;
      prox_pending      <= 1'b0;
      prox_start_time   <= '0;
      prox_flag         <= 1'b0;
      wave_state        <= PH_IDLE;
      wave_crossings    <= '0;
      window_start_time <= '0;
      wave_flag         <= 1'b0;
      cooldown_until    <= '0;
    end else if (step) begin
      last_poll_time    <= last_poll_time_next;
      latest_distance   <= latest_distance_next;
      prox_pending      <= prox_pending_next;
      prox_start_time   <= prox_start_time_next;
      prox_flag         <= prox_flag_next;
      wave_state        <= wave_state_next;
      wave_crossings    <= wave_crossings_next;
      window_start_time <= window_start_time_next;
      wave_flag         <= wave_flag_next;
      cooldown_until    <= cooldown_until_next;
    end
  end

  // Output register holds a result until the receiver takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cls_ready) begin
      out_valid <= cls_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.reading_taken   <= taken;
      out_data.proximity_event <= prox_flag_next;
      out_data.wave_event      <= wave_flag_next;
      out_data.last_distance   <= latest_distance_next;
      out_data.wave_phase      <= wave_state_next;
      out_data.crossing_count  <= wave_crossings_next;
    end
  end

endmodule

>>> rtl/tof_proximity_and_wave_gesture_detector_top.sv
// Top level of the time-of-flight proximity and wave gesture detector.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one poll opportunity per
//   beat: a millisecond timestamp, a range byte and two acknowledge bits.
//   Output channel (out_valid/out_ready/out_data) returns exactly one result
//   beat per input beat, in order, with the flags and wave state after it.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes one
//   register per beat; cfg_ready is always high. Write only while idle.
// Path: an accepted input beat passes through the front register, then a queue
//   entry, then the back step into the output register, before its result can
//   be taken.
// Throughput: one beat per cycle while out_ready stays high; the whole detector
//   update is combinational compares and subtracts in the back part.
// Reset: rst is synchronous; all channels empty, registers at their defaults,
//   distance reads as out of range.
// Stall: when out_ready is low the result holds; the two-entry queue and the
//   front register absorb further beats, after which in_ready drops.
module tof_proximity_and_wave_gesture_detector_top
  import tpwg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg;
  logic      cls_valid;
  logic      cls_ready;
  cls_item_t cls_data;
  logic      q_valid;
  logic      q_ready;
  cls_item_t q_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable             <= 1'b0;
      cfg.poll_interval_ms   <= 16'd50;
      cfg.prox_threshold_mm  <= 8'd50;
      cfg.prox_debounce_ms   <= 16'd300;
      cfg.cooldown_ms        <= 16'd1000;
      cfg.wave_near_mm       <= 8'd80;
      cfg.wave_window_ms     <= 16'd1500;
      cfg.wave_min_crossings <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:        cfg.enable             <= cfg_data[0];
        REG_POLL_INTERVAL: cfg.poll_interval_ms   <= cfg_data;
        REG_PROX_THRESH:   cfg.prox_threshold_mm  <= cfg_data[7:0];
        REG_PROX_DEBOUNCE: cfg.prox_debounce_ms   <= cfg_data;
        REG_COOLDOWN:      cfg.cooldown_ms        <= cfg_data;
        REG_WAVE_NEAR:     cfg.wave_near_mm       <= cfg_data[7:0];
        REG_WAVE_WINDOW:   cfg.wave_window_ms     <= cfg_data;
        REG_WAVE_MIN:      cfg.wave_min_crossings <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tpwg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_data  (cls_data)
  );

  tpwg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cls_valid),
    .push_ready (cls_ready),
    .push_data  (cls_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  tpwg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cls_valid (q_valid),
    .cls_ready (q_ready),
    .cls_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/tpwg_checker.sv
// Port-level assertions for the detector top level, bound to it below.
module tpwg_checker
  import tpwg_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result beat stays valid and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // No result can leave in the cycle after a reset cycle.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // The idle wave phase always comes with a cleared crossing count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.wave_phase == PH_IDLE |-> out_data.crossing_count == 8'd0)
    else $error("idle wave phase with nonzero crossing count");

  // An input beat taken while the output is empty shows a result after the front register, queue and back step.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |-> ##3 out_valid)
    else $error("accepted beat did not produce a result");

endmodule

bind tof_proximity_and_wave_gesture_detector_top tpwg_checker u_tpwg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/tb_tof_proximity_and_wave_gesture_detector_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the time-of-flight proximity and wave gesture detector.
module tb_tof_proximity_and_wave_gesture_detector_top;
  import tpwg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_SLACK = 6;
  localparam int LONG_HOLD   = 300;
  localparam int NUM_PHASES  = 8;
  localparam int MAX_REPORTS = 60;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: either a register write or an input beat.
  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    in_item_t    item;
    logic        pinned;
    out_item_t   pinned_out;
  } stim_row_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // Typed-in expectation that travels with the beat it belongs to.
  logic        pin_valid = 1'b0;
  out_item_t   pin_value = '0;

  // Detector state mirrored by the predictor.
  cfg_t        model_cfg;
  logic [31:0] last_poll_ms, prox_since_ms, window_since_ms, quiet_until_ms;
  logic [7:0]  held_distance, crossings;
  logic [1:0]  gesture_phase;
  logic        prox_armed, prox_sticky, wave_sticky;

  out_item_t   expected_results[$];
  stim_row_t   directed_rows[$];

  int errors = 0;
  int cycles = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int readings_taken = 0;
  int prox_events = 0;
  int wave_events = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;

  tof_proximity_and_wave_gesture_detector_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the mirrored detector by one poll and return the result it should report.
  function automatic out_item_t detector_step(in_item_t it);
    logic [31:0] t;
    logic [7:0]  d;
    logic        is_near, is_far, expired;
    out_item_t   r;
    t = it.now_ms;
    d = it.distance_mm;
    r.reading_taken = 1'b0;
    if (it.ack_proximity) prox_sticky = 1'b0;
    if (it.ack_wave) wave_sticky = 1'b0;
    // The cooldown test ignores wrap; the poll interval test does not.
    if (model_cfg.enable && t >= quiet_until_ms &&
        (t - last_poll_ms) >= 32'(model_cfg.poll_interval_ms)) begin
      r.reading_taken = 1'b1;
      last_poll_ms = t;
      held_distance = d;
      // Proximity must persist for the debounce time; the flag is sticky.
      if (d <= model_cfg.prox_threshold_mm) begin
        if (!prox_armed) begin
          prox_armed = 1'b1;
          prox_since_ms = t;
        end else if (!prox_sticky &&
                     (t - prox_since_ms) >= 32'(model_cfg.prox_debounce_ms)) begin
          prox_sticky = 1'b1;
          quiet_until_ms = t + 32'(model_cfg.cooldown_ms);
          prox_events++;
        end
      end else begin
        prox_armed = 1'b0;
        prox_since_ms = '0;
      end
      // Wave gesture: alternate near and far readings inside the window.
      is_near = d <= model_cfg.wave_near_mm;
      is_far  = d == NO_TARGET_MM;
      expired = (t - window_since_ms) > 32'(model_cfg.wave_window_ms);
      case (gesture_phase)
        PH_IDLE: begin
          if (is_near) begin
            gesture_phase = PH_IN;
            crossings = 8'd1;
            window_since_ms = t;
          end
        end
        PH_IN: begin
          if (expired) begin
            gesture_phase = PH_IDLE;
            crossings = '0;
          end else if (is_far) begin
            crossings = crossings + 8'd1;
            gesture_phase = PH_OUT;
          end
        end
        default: begin
          if (expired) begin
            gesture_phase = PH_IDLE;
            crossings = '0;
          end else if (is_near) begin
            crossings = crossings + 8'd1;
            if (crossings >= model_cfg.wave_min_crossings) begin
              wave_sticky = 1'b1;
              gesture_phase = PH_IDLE;
              crossings = '0;
              quiet_until_ms = t + 32'(model_cfg.cooldown_ms);
              wave_events++;
            end else begin
              gesture_phase = PH_IN;
            end
          end
        end
      endcase
    end
    r.proximity_event = prox_sticky;
    r.wave_event      = wave_sticky;
    r.last_distance   = held_distance;
    r.wave_phase      = gesture_phase;
    r.crossing_count  = crossings;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Predict on every accepted input beat and compare every accepted result beat.
  always @(posedge clk) begin : scoreboard
    out_item_t pred;
    out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pred = detector_step(in_data);
        if (pred.reading_taken) readings_taken++;
        expected_results.push_back(pin_valid ? pin_value : pred);
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: result beat with nothing expected, got %h", $time, out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("reading_taken", want.reading_taken, out_data.reading_taken);
          check_field("proximity_event", want.proximity_event, out_data.proximity_event);
          check_field("wave_event", want.wave_event, out_data.wave_event);
          check_field("last_distance", want.last_distance, out_data.last_distance);
          check_field("wave_phase", want.wave_phase, out_data.wave_phase);
          check_field("crossing_count", want.crossing_count, out_data.crossing_count);
          results_checked++;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("tof_proximity_and_wave_gesture_detector_top: mismatch");
    $finish;
  end

  function automatic void add_item(logic [31:0] t, logic [7:0] d, logic ap, logic aw,
                                   logic pinned, out_item_t po);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.item.now_ms = t;
    row.item.distance_mm = d;
    row.item.ack_proximity = ap;
    row.item.ack_wave = aw;
    row.pinned = pinned;
    row.pinned_out = po;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [15:0] val);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.item = '0;
    row.pinned = 1'b0;
    row.pinned_out = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic cfg_t random_setup();
    cfg_t c;
    c.enable             = 1'b1;
    c.poll_interval_ms   = 16'($urandom_range(20, 0));
    c.prox_threshold_mm  = 8'($urandom_range(255, 0));
    c.prox_debounce_ms   = 16'($urandom_range(120, 0));
    c.cooldown_ms        = 16'($urandom_range(300, 0));
    c.wave_near_mm       = 8'($urandom_range(254, 0));
    c.wave_window_ms     = 16'($urandom_range(1200, 30));
    c.wave_min_crossings = 8'($urandom_range(6, 1));
    return c;
  endfunction

  // Offer one input beat, after a random idle gap, and return at the edge that takes it.
  task automatic send_item(in_item_t it, logic pinned, out_item_t pinned_out);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    pin_valid <= pinned;
    pin_value <= pinned_out;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering beats and wait until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLE:        model_cfg.enable = val[0];
      REG_POLL_INTERVAL: model_cfg.poll_interval_ms = val;
      REG_PROX_THRESH:   model_cfg.prox_threshold_mm = val[7:0];
      REG_PROX_DEBOUNCE: model_cfg.prox_debounce_ms = val;
      REG_COOLDOWN:      model_cfg.cooldown_ms = val;
      REG_WAVE_NEAR:     model_cfg.wave_near_mm = val[7:0];
      REG_WAVE_WINDOW:   model_cfg.wave_window_ms = val;
      REG_WAVE_MIN:      model_cfg.wave_min_crossings = val[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(cfg_t c);
    cfg_write(REG_ENABLE, {15'b0, c.enable});
    cfg_write(REG_POLL_INTERVAL, c.poll_interval_ms);
    cfg_write(REG_PROX_THRESH, {8'b0, c.prox_threshold_mm});
    cfg_write(REG_PROX_DEBOUNCE, c.prox_debounce_ms);
    cfg_write(REG_COOLDOWN, c.cooldown_ms);
    cfg_write(REG_WAVE_NEAR, {8'b0, c.wave_near_mm});
    cfg_write(REG_WAVE_WINDOW, c.wave_window_ms);
    cfg_write(REG_WAVE_MIN, {8'b0, c.wave_min_crossings});
  endtask

  initial begin : stimulus
    stim_row_t   row;
    in_item_t    item;
    cfg_t        setup;
    out_item_t   after_reset;
    int          phase_items;
    int          pattern;
    int          pattern_left;
    logic        level_near;
    logic [31:0] stim_now;
    logic [7:0]  reading_mm;

    // Mirror of the register defaults and the cleared state.
    model_cfg.enable             = 1'b0;
    model_cfg.poll_interval_ms   = 16'd50;
    model_cfg.prox_threshold_mm  = 8'd50;
    model_cfg.prox_debounce_ms   = 16'd300;
    model_cfg.cooldown_ms        = 16'd1000;
    model_cfg.wave_near_mm       = 8'd80;
    model_cfg.wave_window_ms     = 16'd1500;
    model_cfg.wave_min_crossings = 8'd3;
    last_poll_ms    = '0;
    prox_since_ms   = '0;
    window_since_ms = '0;
    quiet_until_ms  = '0;
    held_distance   = NO_TARGET_MM;
    crossings       = '0;
    gesture_phase   = PH_IDLE;
    prox_armed      = 1'b0;
    prox_sticky     = 1'b0;
    wave_sticky     = 1'b0;

    after_reset = '{reading_taken: 1'b0, proximity_event: 1'b0, wave_event: 1'b0,
                    last_distance: NO_TARGET_MM, wave_phase: PH_IDLE,
                    crossing_count: 8'd0};

    // Disabled after reset: nothing is taken, whatever the fields hold.
    add_item(32'h0000_0000, 8'd0, 1'b0, 1'b0, 1'b1, after_reset);
    add_item(32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1, 1'b1, after_reset);
    add_cfg(REG_ENABLE, 16'd1);
    add_cfg(REG_POLL_INTERVAL, 16'd10);
    add_cfg(REG_PROX_THRESH, 16'd50);
    add_cfg(REG_PROX_DEBOUNCE, 16'd20);
    add_cfg(REG_COOLDOWN, 16'd100);
    add_cfg(REG_WAVE_NEAR, 16'd80);
    add_cfg(REG_WAVE_WINDOW, 16'd500);
    add_cfg(REG_WAVE_MIN, 16'd3);
    // Near, too soon, far, near again completes a three-crossing wave.
    add_item(32'd1000, 8'd30, 1'b0, 1'b0, 1'b0, '0);
    add_item(32'd1005, 8'd30, 1'b0, 1'b0, 1'b0, '0);
    add_item(32'd1010, 8'd255, 1'b0, 1'b0, 1'b0, '0);
    add_item(32'd1020, 8'd40, 1'b0, 1'b0, 1'b0, '0);
    // Inside the cooldown, then proximity fires once it ends.
    add_item(32'd1050, 8'd40, 1'b0, 1'b0, 1'b0, '0);
    add_item(32'd1120, 8'd40, 1'b0, 1'b1, 1'b0, '0);
    // Sticky proximity holds off a second event until it is acknowledged.
    add_item(32'd1230, 8'd40, 1'b0, 1'b0, 1'b0, '0);
    add_item(32'd1240, 8'd40, 1'b1, 1'b0, 1'b0, '0);
    // A gesture that outlives its window falls back to idle.
    add_item(32'd1400, 8'd70, 1'b0, 1'b0, 1'b0, '0);
    add_item(32'd2000, 8'd255, 1'b0, 1'b0, 1'b0, '0);
    // Out of range counts as near too, and a zero minimum completes at the first near reading in the out phase.
    add_cfg(REG_WAVE_NEAR, 16'd255);
    add_cfg(REG_WAVE_MIN, 16'd0);
    add_item(32'd3000, 8'd255, 1'b0, 1'b0, 1'b0, '0);
    add_item(32'd3010, 8'd255, 1'b0, 1'b0, 1'b0, '0);
    add_item(32'd3020, 8'd255, 1'b0, 1'b1, 1'b0, '0);
    add_item(32'd3030, 8'd255, 1'b0, 1'b0, 1'b0, '0);
    // Timestamps that wrap: the cooldown end wraps and the compare does not.
    add_cfg(REG_COOLDOWN, 16'd1000);
    add_item(32'hFFFF_FFE0, 8'd10, 1'b1, 1'b1, 1'b0, '0);
    add_item(32'hFFFF_FFF8, 8'd10, 1'b0, 1'b0, 1'b0, '0);
    add_item(32'h0000_0005, 8'd10, 1'b0, 1'b0, 1'b0, '0);
    add_item(32'h0000_0400, 8'd10, 1'b1, 1'b0, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        cfg_write(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.item, row.pinned, row.pinned_out);
      end
    end

    // Random phases, each under its own settings and handshake pressure.
    stim_now = 32'h0000_0400;
    pattern_left = 0;
    pattern = 0;
    level_near = 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      setup = random_setup();
      phase_items = 190;
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; setup.wave_min_crossings = 8'd1; end
        3: begin
          idle_pct = 35; stall_pct = 35;
          setup = '{enable: 1'b1, poll_interval_ms: 16'hFFFF, prox_threshold_mm: 8'hFF,
                    prox_debounce_ms: 16'hFFFF, cooldown_ms: 16'hFFFF,
                    wave_near_mm: 8'hFF, wave_window_ms: 16'hFFFF,
                    wave_min_crossings: 8'hFF};
        end
        4: begin
          idle_pct = 35; stall_pct = 35;
          setup = '{enable: 1'b1, default: '0};
        end
        5: begin idle_pct = 35; stall_pct = 35; stim_now = 32'hFFFF_F800; end
        6: begin idle_pct = 0;  stall_pct = 0;  setup.enable = 1'b0; phase_items = 60; end
        default: begin
          idle_pct = 35; stall_pct = 35;
          setup.wave_near_mm = 8'hFF;
          setup.wave_min_crossings = 8'd0;
        end
      endcase
      set_config(setup);
      for (int n = 0; n < phase_items; n++) begin
        // Long output hold-off while the sender keeps going, so the block backs up.
        if (p == 0 && n == 80) hold_requests++;
        if ($urandom_range(49) == 0)
          stim_now = stim_now + $urandom;
        else
          stim_now = stim_now + $urandom_range(model_cfg.poll_interval_ms + 30, 0);
        // Mostly gesture-like near/far runs, some held proximity, some noise.
        if (pattern_left == 0) begin
          pattern = $urandom_range(9);
          pattern_left = $urandom_range(16, 4);
          level_near = 1'b1;
        end
        pattern_left--;
        if (pattern < 6) begin
          reading_mm = level_near ? 8'($urandom_range(model_cfg.wave_near_mm, 0))
                                  : NO_TARGET_MM;
          if ($urandom_range(9) < 7) level_near = !level_near;
        end else if (pattern < 8) begin
          reading_mm = 8'($urandom_range(model_cfg.prox_threshold_mm, 0));
        end else begin
          reading_mm = 8'($urandom_range(255, 0));
        end
        item.now_ms        = stim_now;
        item.distance_mm   = reading_mm;
        item.ack_proximity = ($urandom_range(9) == 0);
        item.ack_wave      = ($urandom_range(9) == 0);
        send_item(item, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("Covered %0d beats (directed table and %0d random phases) in %0d cycles.",
             items_accepted, NUM_PHASES, cycles);
    $display("Readings taken %0d, proximity events %0d, wave events %0d, results checked %0d.",
             readings_taken, prox_events, wave_events, results_checked);
    if (errors == 0) begin
      $display("tof_proximity_and_wave_gesture_detector_top: match");
    end else begin
      $display("tof_proximity_and_wave_gesture_detector_top: mismatch");
    end
    $finish;
  end

endmodule

>>> tof_proximity_and_wave_gesture_detector_top.f
rtl/tpwg_pkg.sv
rtl/tpwg_front.sv
rtl/tpwg_queue.sv
rtl/tpwg_back.sv
rtl/tof_proximity_and_wave_gesture_detector_top.sv
rtl/tpwg_checker.sv
tb/tb_tof_proximity_and_wave_gesture_detector_top.sv
